[rtl/aelf_pkg.sv]
// Shared types, protocol codes and frame constants for the absolute encoder link block.
// No dependencies. Used by every module of the block.
package aelf_pkg;

    // Reply buffer sizing.
    localparam int MAX_REPLY_BYTES = 11;
    localparam int STORE_IDX_W     = $clog2(MAX_REPLY_BYTES);
    localparam int CNT_W           = $clog2(MAX_REPLY_BYTES + 1);
    localparam int LEN_W           = 4;
    localparam int BEATS_MAX       = 4;
    localparam int BEAT_CNT_W      = 3;
    localparam int BEAT_IDX_W      = 2;

    // Input command codes.
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RX_BYTE = 1'b1;

    // Result kinds.
    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Data IDs.
    localparam logic [3:0] ID_ABS_POS     = 4'h0;
    localparam logic [3:0] ID_MULTI_TURN  = 4'h1;
    localparam logic [3:0] ID_ENC_ID      = 4'h2;
    localparam logic [3:0] ID_FULL        = 4'h3;
    localparam logic [3:0] ID_EE_WRITE    = 4'h6;
    localparam logic [3:0] ID_RESET_ALARM = 4'h7;
    localparam logic [3:0] ID_RESET_MULTI = 4'h8;
    localparam logic [3:0] ID_ABS_POS_ALT = 4'hC;
    localparam logic [3:0] ID_EE_READ     = 4'hD;

    // Control field bytes sent for each ID.
    localparam logic [7:0] OP_ABS_POS     = 8'h02;
    localparam logic [7:0] OP_MULTI_TURN  = 8'h8A;
    localparam logic [7:0] OP_ENC_ID      = 8'h92;
    localparam logic [7:0] OP_FULL        = 8'h1A;
    localparam logic [7:0] OP_EE_WRITE    = 8'h32;
    localparam logic [7:0] OP_RESET_ALARM = 8'hBA;
    localparam logic [7:0] OP_RESET_MULTI = 8'hC2;
    localparam logic [7:0] OP_ABS_POS_ALT = 8'h62;
    localparam logic [7:0] OP_EE_READ     = 8'hEA;

    // Reply lengths in bytes.
    localparam logic [LEN_W-1:0] LEN_NONE  = 4'd0;
    localparam logic [LEN_W-1:0] LEN_SHORT = 4'd4;
    localparam logic [LEN_W-1:0] LEN_STD   = 4'd6;
    localparam logic [LEN_W-1:0] LEN_FULL  = 4'd11;

    // Beats produced by one request.
    localparam logic [BEAT_CNT_W-1:0] BEATS_NONE     = 3'd0;
    localparam logic [BEAT_CNT_W-1:0] BEATS_SINGLE   = 3'd1;
    localparam logic [BEAT_CNT_W-1:0] BEATS_EE_READ  = 3'd3;
    localparam logic [BEAT_CNT_W-1:0] BEATS_EE_WRITE = 3'd4;

    typedef struct packed {
        logic       cmd;
        logic [3:0] request_id;
        logic [7:0] eeprom_address;
        logic [7:0] eeprom_data;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  control_field;
        logic [7:0]  status_field;
        logic [23:0] single_turn;
        logic [23:0] multi_turn;
        logic [7:0]  device_id;
        logic [7:0]  alarm_count;
        logic [7:0]  eeprom_address_rx;
        logic [7:0]  eeprom_data_rx;
        logic [7:0]  frame_crc;
    } report_t;

    // Everything one accepted item produces, before it is split into beats.
    typedef struct packed {
        logic                           kind;
        logic [BEAT_CNT_W-1:0]          count;
        logic [BEATS_MAX-1:0][7:0]      tx_bytes;
        report_t                        report;
    } bundle_t;

    // One result beat as it sits in the output register.
    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last_tx;
        report_t    report;
    } beat_t;

endpackage

[rtl/absolute_encoder_link_frames.sv]
// Path: a beat accepted on s_ is registered in the input register, turned by the engine into a
// bundle in the bundle register, and its first result beat is then registered for m_.
// Throughput: one result beat per cycle while m_ready holds; a request gives 1, 3 or 4 beats
// (one per frame byte) and a completed reply one beat, split by bundle and output registers.
// Reset: aresetn is synchronous, active low; it clears the link state, the held reply fields
// and all valid flags. The reply byte buffer is not cleared and holds no meaning until written.
module absolute_encoder_link_frames
    import aelf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [3:0]  s_request_id,
    input  logic [7:0]  s_eeprom_address,
    input  logic [7:0]  s_eeprom_data,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_tx_byte,
    output logic        m_last_tx,
    output logic [7:0]  m_control_field,
    output logic [7:0]  m_status_field,
    output logic [23:0] m_single_turn,
    output logic [23:0] m_multi_turn,
    output logic [7:0]  m_device_id,
    output logic [7:0]  m_alarm_count,
    output logic [7:0]  m_eeprom_address_rx,
    output logic [7:0]  m_eeprom_data_rx,
    output logic [7:0]  m_frame_crc
);

    // Input register. An input beat waits here until the bundle register can take
    // everything it produces; a new beat is accepted in the same cycle the old one moves on.
    item_t   in_reg;
    logic    in_valid_reg, in_valid_next;
    logic    in_take;
    logic    bundle_free;
    bundle_t bundle;
    beat_t   beat;

    assign in_take = in_valid_reg && bundle_free;
    assign s_ready = !in_valid_reg || in_take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.cmd            <= s_cmd;
            in_reg.request_id     <= s_request_id;
            in_reg.eeprom_address <= s_eeprom_address;
            in_reg.eeprom_data    <= s_eeprom_data;
            in_reg.rx_byte        <= s_rx_byte;
        end
    end

    // The engine updates the link state for the taken beat and builds its result bundle:
    // the command frame bytes of a request, or the parsed report when a reply completes.
    // Beats that produce nothing (unknown IDs, stray or extra reply bytes) leave no bundle.
    aelf_frame_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (in_take),
        .item    (in_reg),
        .bundle  (bundle)
    );

    // The emitter walks the bundle one beat per cycle, while m_ready holds, into the output register.
    aelf_beat_emitter u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bundle_load (in_take && (bundle.count != BEATS_NONE)),
        .bundle_in   (bundle),
        .bundle_free (bundle_free),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .beat        (beat)
    );

    assign m_kind              = beat.kind;
    assign m_tx_byte           = beat.tx_byte;
    assign m_last_tx           = beat.last_tx;
    assign m_control_field     = beat.report.control_field;
    assign m_status_field      = beat.report.status_field;
    assign m_single_turn       = beat.report.single_turn;
    assign m_multi_turn        = beat.report.multi_turn;
    assign m_device_id         = beat.report.device_id;
    assign m_alarm_count       = beat.report.alarm_count;
    assign m_eeprom_address_rx = beat.report.eeprom_address_rx;
    assign m_eeprom_data_rx    = beat.report.eeprom_data_rx;
    assign m_frame_crc         = beat.report.frame_crc;

endmodule

[rtl/aelf_frame_engine.sv]
// Protocol engine: request decode, command frame build, reply capture and field parse.
// Depends on aelf_pkg. Holds the link state and the held reply fields.
module aelf_frame_engine
    import aelf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    take,
    input  item_t   item,
    output bundle_t bundle
);

    logic [3:0]       active_id_reg, active_id_next;
    logic [LEN_W-1:0] expected_length_reg, expected_length_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       frame_store_reg [MAX_REPLY_BYTES];
    report_t          held_reg, held_next;

    logic             id_known;
    logic [7:0]       op;
    logic [LEN_W-1:0] len;
    logic             store_en;
    logic [CNT_W-1:0] count_inc;
    logic [7:0]       view [MAX_REPLY_BYTES];

    always_comb begin
        id_known = 1'b1;
        op       = '0;
        len      = LEN_NONE;
        unique case (item.request_id)
            ID_ABS_POS: begin
                op = OP_ABS_POS; len = LEN_STD;
            end
            ID_MULTI_TURN: begin
                op = OP_MULTI_TURN; len = LEN_STD;
            end
            ID_ENC_ID: begin
                op = OP_ENC_ID; len = LEN_SHORT;
            end
            ID_FULL: begin
                op = OP_FULL; len = LEN_FULL;
            end
            ID_EE_WRITE: begin
                op = OP_EE_WRITE; len = LEN_SHORT;
            end
            ID_RESET_ALARM: begin
                op = OP_RESET_ALARM; len = LEN_STD;
            end
            ID_RESET_MULTI: begin
                op = OP_RESET_MULTI; len = LEN_STD;
            end
            ID_ABS_POS_ALT: begin
                op = OP_ABS_POS_ALT; len = LEN_STD;
            end
            ID_EE_READ: begin
                op = OP_EE_READ; len = LEN_SHORT;
            end
            default: begin
                id_known = 1'b0;
            end
        endcase
    end

    assign store_en  = (item.cmd == CMD_RX_BYTE)
                     && (byte_count_reg < CNT_W'(expected_length_reg))
                     && (byte_count_reg < CNT_W'(MAX_REPLY_BYTES));
    assign count_inc = byte_count_reg + CNT_W'(1);

    // The frame as it stands once the incoming byte has been written.
    always_comb begin
        for (int i = 0; i < MAX_REPLY_BYTES; i++) begin
            view[i] = (byte_count_reg == CNT_W'(i)) ? item.rx_byte : frame_store_reg[i];
        end
    end

    always_comb begin
        active_id_next       = active_id_reg;
        expected_length_next = expected_length_reg;
        byte_count_next      = byte_count_reg;
        held_next            = held_reg;
        bundle               = '0;

        if (take) begin
            if (item.cmd == CMD_REQUEST) begin
                if (id_known) begin
                    active_id_next       = item.request_id;
                    expected_length_next = len;
                    byte_count_next      = '0;
                    bundle.kind          = KIND_TX;
                    bundle.tx_bytes[0]   = op;
                    bundle.tx_bytes[1]   = item.eeprom_address;
                    bundle.tx_bytes[2]   = (item.request_id == ID_EE_WRITE) ?
                                           item.eeprom_data : (op ^ item.eeprom_address);
                    bundle.tx_bytes[3]   = op ^ item.eeprom_address ^ item.eeprom_data;
                    if (item.request_id == ID_EE_WRITE) begin
                        bundle.count = BEATS_EE_WRITE;
                    end else if (item.request_id == ID_EE_READ) begin
                        bundle.count = BEATS_EE_READ;
                    end else begin
                        bundle.count = BEATS_SINGLE;
                    end
                end
            end else if (store_en) begin
                byte_count_next = count_inc;
                if (count_inc == CNT_W'(expected_length_reg)) begin
                    unique case (active_id_reg)
                        ID_ABS_POS, ID_ABS_POS_ALT: begin
                            held_next.control_field = view[0];
                            held_next.status_field  = view[1];
                            held_next.single_turn   = {view[4], view[3], view[2]};
                            held_next.frame_crc     = view[5];
                        end
                        ID_MULTI_TURN: begin
                            held_next.control_field = view[0];
                            held_next.status_field  = view[1];
                            held_next.multi_turn    = {view[4], view[3], view[2]};
                            held_next.frame_crc     = view[5];
                        end
                        ID_ENC_ID: begin
                            held_next.control_field = view[0];
                            held_next.status_field  = view[1];
                            held_next.device_id     = view[2];
                            held_next.frame_crc     = view[3];
                        end
                        ID_FULL: begin
                            held_next.control_field = view[0];
                            held_next.status_field  = view[1];
                            held_next.single_turn   = {view[4], view[3], view[2]};
                            held_next.device_id     = view[5];
                            held_next.multi_turn    = {view[8], view[7], view[6]};
                            held_next.alarm_count   = view[9];
                            held_next.frame_crc     = view[10];
                        end
                        ID_EE_READ: begin
                            held_next.control_field     = view[0];
                            held_next.eeprom_address_rx = view[1];
                            held_next.eeprom_data_rx    = view[2];
                            held_next.frame_crc         = view[3];
                        end
                        default: begin
                        end
                    endcase
                    bundle.kind   = KIND_REPLY;
                    bundle.count  = BEATS_SINGLE;
                    bundle.report = held_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_id_reg       <= '0;
            expected_length_reg <= LEN_NONE;
            byte_count_reg      <= '0;
            held_reg            <= '0;
        end else begin
            active_id_reg       <= active_id_next;
            expected_length_reg <= expected_length_next;
            byte_count_reg      <= byte_count_next;
            held_reg            <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && store_en) begin
            frame_store_reg[byte_count_reg[STORE_IDX_W-1:0]] <= item.rx_byte;
        end
    end

`ifndef SYNTHESIS
    a_count_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= CNT_W'(expected_length_reg))
        else $error("reply byte count ran past the expected length");

    a_length_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        expected_length_reg == LEN_NONE || expected_length_reg == LEN_SHORT ||
        expected_length_reg == LEN_STD || expected_length_reg == LEN_FULL)
        else $error("expected reply length is not a protocol length");

    a_full_length_id: assert property (@(posedge aclk) disable iff (!aresetn)
        expected_length_reg == LEN_FULL |-> active_id_reg == ID_FULL)
        else $error("full-length reply armed for an ID other than the full status ID");
`endif

endmodule

[rtl/aelf_beat_emitter.sv]
// Bundle register and output register: splits one item's results into result beats.
// Depends on aelf_pkg.
module aelf_beat_emitter
    import aelf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    bundle_load,
    input  bundle_t bundle_in,
    output logic    bundle_free,
    input  logic    m_ready,
    output logic    m_valid,
    output beat_t   beat
);

    bundle_t               bnd_reg;
    logic                  bnd_valid_reg, bnd_valid_next;
    logic [BEAT_IDX_W-1:0] bnd_idx_reg, bnd_idx_next;
    beat_t                 out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  load_beat;
    logic                  beat_last;
    logic [BEAT_CNT_W-1:0] last_idx;

    assign last_idx    = bnd_reg.count - BEAT_CNT_W'(1);
    assign beat_last   = ({1'b0, bnd_idx_reg} == last_idx);
    assign load_beat   = bnd_valid_reg && (!out_valid_reg || m_ready);
    assign bundle_free = !bnd_valid_reg || (load_beat && beat_last);

    always_comb begin
        bnd_valid_next = bnd_valid_reg;
        bnd_idx_next   = bnd_idx_reg;
        if (bundle_load) begin
            bnd_valid_next = 1'b1;
            bnd_idx_next   = '0;
        end else if (load_beat && beat_last) begin
            bnd_valid_next = 1'b0;
        end else if (load_beat) begin
            bnd_idx_next = bnd_idx_reg + BEAT_IDX_W'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load_beat) begin
            out_valid_next = 1'b1;
            out_next.kind  = bnd_reg.kind;
            if (bnd_reg.kind == KIND_REPLY) begin
                out_next.tx_byte = '0;
                out_next.last_tx = 1'b0;
                out_next.report  = bnd_reg.report;
            end else begin
                out_next.tx_byte = bnd_reg.tx_bytes[bnd_idx_reg];
                out_next.last_tx = beat_last;
                out_next.report  = '0;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bnd_valid_reg <= 1'b0;
            bnd_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            bnd_valid_reg <= bnd_valid_next;
            bnd_idx_reg   <= bnd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (bundle_load) begin
            bnd_reg <= bundle_in;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign beat    = out_reg;

`ifndef SYNTHESIS
    a_idx_in_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        bnd_valid_reg |-> (bnd_reg.count != BEATS_NONE) && ({1'b0, bnd_idx_reg} < bnd_reg.count))
        else $error("beat index outside the held bundle");

    a_reply_single: assert property (@(posedge aclk) disable iff (!aresetn)
        bnd_valid_reg && bnd_reg.kind == KIND_REPLY |-> bnd_reg.count == BEATS_SINGLE)
        else $error("reply bundle holds more than one beat");

    a_reply_beat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.kind == KIND_REPLY |-> out_reg.tx_byte == 8'h00 && !out_reg.last_tx)
        else $error("reply beat carries transmit data");
`endif

endmodule
